// ----- src/rau_pkg.sv -----
package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam int PROD_BITS = 2 * WORD_BITS;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_LT  = 3'd4;
    localparam logic [2:0] CMD_GT  = 3'd5;
    localparam logic [2:0] CMD_EQ  = 3'd6;
    localparam logic [2:0] CMD_NE  = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    typedef struct packed {
        logic [2:0]                  command;
        logic signed [WORD_BITS-1:0] left_num;
        logic signed [WORD_BITS-1:0] left_den;
        logic signed [WORD_BITS-1:0] right_num;
        logic signed [WORD_BITS-1:0] right_den;
    } t_rau_in;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] result_num;
        logic [WORD_BITS-2:0]        result_den;
        logic                        compare_true;
        logic [1:0]                  status;
    } t_rau_out;

endpackage

// ----- src/rational_arithmetic_unit.sv -----
// Zero-denominator and divide-by-zero errors are flagged from idle; comparisons and
// zero results end after the products, and reduced arithmetic runs the gcd and divisions.
// One transfer at a time; busy stays high until the result strobe.
// The binary gcd loop (shift, swap, subtract) and two 64-step restoring
// divisions share one 66-bit subtractor; there is no output stall.
// Reset (synchronous, active low) returns to idle and drops the strobe.
module rational_arithmetic_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  rau_pkg::t_rau_in i_operands,
    output logic            busy,
    output logic            o_done,
    output rau_pkg::t_rau_out o_result
);
    import rau_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_COMB = 3'd2;
    localparam logic [2:0] S_GCD  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;

    localparam int W = WORD_BITS;
    localparam int P = PROD_BITS;
    localparam int KB = $clog2(P);

    logic [2:0]   r_state;
    logic [2:0]   r_cmd;
    logic [W-1:0] r_lnm, r_ldm, r_rnm, r_rdm;   // operand magnitudes
    logic         r_sl, r_sr;                   // operand signs
    logic [1:0]   r_step;
    logic [P-1:0] r_p, r_q, r_d;                // cross products
    logic [P-1:0] r_num, r_den;                 // unreduced result
    logic         r_neg;
    logic [P-1:0] r_u, r_v;                     // gcd working pair
    logic [KB-1:0] r_k;                         // common power of two
    logic [P-1:0] r_g;                          // odd part of the gcd
    logic [P:0]   r_rem;
    logic [P-1:0] r_dvd, r_quo, r_qnum;
    logic [KB-1:0] r_cnt;
    logic         r_pass;                       // 0: numerator, 1: denominator
    logic         r_done;
    t_rau_out     r_out;

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        mag = x[W-1] ? (~x + 1'b1) : x;
    endfunction

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

    // Shared multiplier: one 32x32 product per cycle, registered
    logic [W-1:0] mul_a, mul_b;
    logic [P-1:0] mul_y;
    always_comb begin
        mul_a = r_ldm;
        mul_b = r_rdm;
        case (r_step)
            2'd0: begin
                mul_a = r_lnm;
                mul_b = (r_cmd == CMD_MUL) ? r_rnm : r_rdm;
            end
            2'd1: begin
                mul_a = r_rnm;
                mul_b = r_ldm;
            end
            default: begin
                mul_a = r_ldm;
                mul_b = r_rdm;
            end
        endcase
        mul_y = mul_a * mul_b;
    end

    // Shared subtractor: compare, gcd step and division step
    logic [P:0]   sub_a, sub_b;
    logic [P+1:0] diff;
    logic [P:0]   rs;
    always_comb begin
        rs = {r_rem[P-1:0], r_dvd[P-1]};
        unique case (r_state)
            S_COMB: begin
                sub_a = {1'b0, r_p};
                sub_b = {1'b0, r_q};
            end
            S_GCD: begin
                sub_a = {1'b0, r_u};
                sub_b = {1'b0, r_v};
            end
            default: begin
                sub_a = rs;
                sub_b = {1'b0, r_g};
            end
        endcase
        diff = {1'b0, sub_a} - {1'b0, sub_b};
    end

    // Comparison of signed cross products
    logic signed [P:0] xs, ys;
    logic              flag;
    logic              neg_r;
    always_comb begin
        xs = r_sl ? -$signed({1'b0, r_p}) : $signed({1'b0, r_p});
        ys = r_sr ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        case (r_cmd)
            CMD_LT:  flag = (xs < ys);
            CMD_GT:  flag = (xs > ys);
            CMD_EQ:  flag = (xs == ys);
            default: flag = (xs != ys);
        endcase
        neg_r = (r_cmd == CMD_SUB) ? ~r_sr : r_sr;
    end

    // Final value of the division pass
    logic [P-1:0] quo_n;
    logic         qbit;
    logic         ovf;
    logic [W-1:0] fin_num;
    always_comb begin
        qbit  = ~diff[P+1];
        quo_n = {r_quo[P-2:0], qbit};
        ovf   = (|quo_n[P-1:W-1]) ||
                (r_neg ? ((|r_qnum[P-1:W]) || (r_qnum[W-1] && (|r_qnum[W-2:0])))
                       : (|r_qnum[P-1:W-1]));
        fin_num = r_neg ? (~r_qnum[W-1:0] + 1'b1) : r_qnum[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd  <= i_operands.command;
                        r_lnm  <= mag(i_operands.left_num);
                        r_ldm  <= mag(i_operands.left_den);
                        r_rnm  <= mag(i_operands.right_num);
                        r_rdm  <= mag(i_operands.right_den);
                        r_sl   <= i_operands.left_num[W-1] ^ i_operands.left_den[W-1];
                        r_sr   <= i_operands.right_num[W-1] ^ i_operands.right_den[W-1];
                        r_step <= 2'd0;
                        if (i_operands.left_den == '0 || i_operands.right_den == '0) begin
                            r_out  <= '{result_num: '0, result_den: '0,
                                       compare_true: 1'b0, status: ST_ZDEN};
                            r_done <= 1'b1;
                        end else if (i_operands.command == CMD_DIV &&
                                     i_operands.right_num == '0) begin
                            r_out  <= '{result_num: '0, result_den: '0,
                                       compare_true: 1'b0, status: ST_DIVZ};
                            r_done <= 1'b1;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    // Three products: p, q, then the denominator product
                    case (r_step)
                        2'd0:    r_p <= mul_y;
                        2'd1:    r_q <= mul_y;
                        default: r_d <= mul_y;
                    endcase
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd2) begin
                        r_state <= S_COMB;
                    end
                end
                S_COMB: begin
                    if (r_cmd[2]) begin
                        r_out   <= '{result_num: '0, result_den: (W-1)'(1),
                                    compare_true: flag, status: ST_OK};
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        logic [P-1:0] num, den;
                        logic         ng;
                        num = r_p;
                        den = r_d;
                        ng  = r_sl ^ r_sr;
                        if (r_cmd == CMD_ADD || r_cmd == CMD_SUB) begin
                            if (r_sl == neg_r) begin
                                num = r_p + r_q;
                                ng  = r_sl;
                            end else if (!diff[P+1]) begin
                                num = diff[P-1:0];
                                ng  = r_sl;
                            end else begin
                                num = r_q - r_p;
                                ng  = neg_r;
                            end
                        end else if (r_cmd == CMD_DIV) begin
                            den = r_q;
                        end
                        r_num <= num;
                        r_den <= den;
                        r_neg <= ng;
                        r_u   <= num;
                        r_v   <= den;
                        r_k   <= '0;
                        if (num == '0) begin
                            r_out   <= '{result_num: '0, result_den: (W-1)'(1),
                                        compare_true: 1'b0, status: ST_OK};
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_GCD;
                        end
                    end
                end
                S_GCD: begin
                    // Binary gcd: one shift, swap or subtract per cycle
                    if (!r_u[0] && !r_v[0]) begin
                        r_u <= r_u >> 1;
                        r_v <= r_v >> 1;
                        r_k <= r_k + 1'b1;
                    end else if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (diff == '0) begin
                        r_g     <= r_u;
                        r_dvd   <= r_num >> r_k;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_pass  <= 1'b0;
                        r_state <= S_DIV;
                    end else if (diff[P+1]) begin
                        r_u <= r_v;
                        r_v <= r_u;
                    end else begin
                        r_u <= diff[P-1:0];
                    end
                end
                S_DIV: begin
                    // Restoring division by the odd gcd, one bit per cycle
                    if (r_cnt != KB'(P - 1)) begin
                        r_rem <= qbit ? diff[P:0] : rs;
                        r_quo <= quo_n;
                        r_dvd <= r_dvd << 1;
                        r_cnt <= r_cnt + 1'b1;
                    end else if (!r_pass) begin
                        r_qnum <= quo_n;
                        r_pass <= 1'b1;
                        r_dvd  <= r_den >> r_k;
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_cnt  <= '0;
                    end else begin
                        if (ovf) begin
                            r_out <= '{result_num: '0, result_den: '0,
                                      compare_true: 1'b0, status: ST_OVF};
                        end else begin
                            r_out <= '{result_num: fin_num,
                                      result_den: quo_n[W-2:0],
                                      compare_true: 1'b0, status: ST_OK};
                        end
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // An error result carries a zero fraction
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |->
            (o_result.result_den == '0 && o_result.result_num == '0))
        else $error("error result not zeroed");

    // A true comparison reports a denominator of 1
    a_cmp_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.compare_true) |-> (o_result.result_den == 1))
        else $error("comparison result denominator");

    // The divisor of the reduction is odd and nonzero
    a_div_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_g[0])
        else $error("gcd divisor not odd");

    // A strobe follows a transfer or work in progress
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> ($past(start) || $past(busy)))
        else $error("spurious result strobe");

endmodule
